FILE: rtl/midi_overlapping_note_filter_macros.svh
// Assertion macros used by the checker file.
`ifndef MIDI_OVERLAPPING_NOTE_FILTER_MACROS_SVH
`define MIDI_OVERLAPPING_NOTE_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MOFILT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MOFILT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mofilt_pkg.sv
package mofilt_pkg;

    localparam int NOTE_COUNT_DEF    = 128;
    localparam int CHANNEL_COUNT_DEF = 16;

    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FILTER_ENABLE = 1'b0;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic       last;
    } msg_t;

    typedef struct packed {
        logic [1:0] count;
        msg_t       first;
        msg_t       second;
    } push_t;

endpackage

FILE: rtl/midi_overlapping_note_filter.sv
// Channel  | Handshake                       | Payload
// input    | in_valid / in_ready             | status_byte, data_one, data_two
// output   | out_valid / out_ready           | out_status, out_data_one, out_data_two,
//          |                                 | last_of_run
// config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// An item is taken every cycle while results drain; an item that causes two results
// presents them on the output port one after the other.
// An item waits in the stage-one registers, then its results enter the output queue.
// After reset the held-note memory is cleared one row a cycle, from row 0 to CHANNEL_COUNT-1;
// no item is accepted while it clears.
// A stalled output gathers three or four results and one waiting item before in_ready falls.
module midi_overlapping_note_filter
    import mofilt_pkg::*;
#(
    parameter int NOTE_COUNT    = NOTE_COUNT_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         data_one,
    input  logic [7:0]         data_two,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_status,
    output logic [7:0]         out_data_one,
    output logic [7:0]         out_data_two,
    output logic               last_of_run,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic  filter_enable_reg;
    logic  cfg_wr, room;
    push_t push;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1] == REG_FILTER_ENABLE);
    assign prdata = (paddr[PADDR_W-1] == REG_FILTER_ENABLE)
                  ? {{(PDATA_W-1){1'b0}}, filter_enable_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            filter_enable_reg <= pwdata[0];
        end
    end

    mofilt_track #(
        .NOTE_COUNT    (NOTE_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .status_byte   (status_byte),
        .data_one      (data_one),
        .data_two      (data_two),
        .filter_enable (filter_enable_reg),
        .room          (room),
        .push          (push)
    );

    mofilt_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_status   (out_status),
        .out_data_one (out_data_one),
        .out_data_two (out_data_two),
        .last_of_run  (last_of_run)
    );

endmodule

FILE: rtl/mofilt_ram.sv
module mofilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mofilt_track.sv
module mofilt_track
    import mofilt_pkg::*;
#(
    parameter int NOTE_COUNT    = NOTE_COUNT_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_one,
    input  logic [7:0] data_two,
    input  logic       filter_enable,
    input  logic       room,
    output push_t      push
);

    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam logic [4:0] CH_LIMIT = 5'(CHANNEL_COUNT);
    localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);
    localparam logic [AW-1:0] CLR_LAST = AW'(CHANNEL_COUNT - 1);

    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_status_reg, s1_data_one_reg, s1_data_two_reg;
    logic                  fwd_valid_reg;
    logic [NOTE_COUNT-1:0] fwd_row_reg;
    logic                  clr_active_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic                  accept, fire;
    logic [3:0]            kind, chan;
    logic [6:0]            note;
    logic                  is_on, is_off, tracked, held;
    logic [NOTE_COUNT-1:0] ram_rdata, row, new_row;
    logic                  upd_en, ram_wr_en;
    logic [AW-1:0]         upd_addr, ram_wr_addr, rd_addr;
    logic [NOTE_COUNT-1:0] ram_wr_data;
    msg_t                  orig_msg, kill_msg;

    assign accept  = in_valid && in_ready;
    assign in_ready = !clr_active_reg && (!s1_valid_reg || room);
    assign fire    = s1_valid_reg && room;
    assign rd_addr = status_byte[AW-1:0];

    assign kind    = s1_status_reg[7:4];
    assign chan    = s1_status_reg[3:0];
    assign note    = s1_data_one_reg[6:0];
    assign is_on   = (kind == TYPE_NOTE_ON) && (s1_data_two_reg[6:0] != 7'd0);
    assign is_off  = (kind == TYPE_NOTE_OFF)
                  || ((kind == TYPE_NOTE_ON) && (s1_data_two_reg[6:0] == 7'd0));
    assign tracked = ({1'b0, chan} < CH_LIMIT) && ({1'b0, note} < NOTE_LIMIT);
    assign row     = fwd_valid_reg ? fwd_row_reg : ram_rdata;
    assign held    = row[note[NW-1:0]];
    assign upd_addr = chan[AW-1:0];
    assign upd_en  = fire && tracked && (is_on || is_off);

    always_comb
    begin
        new_row = row;
        new_row[note[NW-1:0]] = is_on;
    end

    assign ram_wr_en   = clr_active_reg || upd_en;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : upd_addr;
    assign ram_wr_data = clr_active_reg ? '0 : new_row;

    mofilt_ram #(
        .WIDTH (NOTE_COUNT),
        .DEPTH (CHANNEL_COUNT)
    ) u_held_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        orig_msg = '{status: s1_status_reg, data_one: s1_data_one_reg,
                     data_two: s1_data_two_reg, last: 1'b1};
        kill_msg = '{status: {TYPE_NOTE_OFF, chan}, data_one: {1'b0, note},
                     data_two: 8'd0, last: 1'b0};
        push.first  = orig_msg;
        push.second = orig_msg;
        push.count  = 2'd0;
        if (fire)
        begin
            priority if (tracked && is_on && filter_enable && held)
            begin
                push.first = kill_msg;
                push.count = 2'd2;
            end
            else if (tracked && is_off && filter_enable && !held)
            begin
                push.count = 2'd0;
            end
            else
            begin
                push.count = 2'd1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                fwd_valid_reg <= upd_en && (upd_addr == rd_addr);
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg   <= status_byte;
            s1_data_one_reg <= data_one;
            s1_data_two_reg <= data_two;
            fwd_row_reg     <= new_row;
        end
    end

endmodule

FILE: rtl/mofilt_outq.sv
module mofilt_outq
    import mofilt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_status,
    output logic [7:0] out_data_one,
    output logic [7:0] out_data_two,
    output logic       last_of_run
);

    msg_t                  q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;
    msg_t                  head;

    assign room      = cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign head      = q_reg[rd_ptr_reg];

    assign out_status   = head.status;
    assign out_data_one = head.data_one;
    assign out_data_two = head.data_two;
    assign last_of_run  = head.last;

    assign cnt_next = cnt_reg + OUTQ_CNT_W'(push.count) - OUTQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_reg + OUTQ_PTR_W'(1)] <= push.second;
        end
    end

endmodule

FILE: rtl/mofilt_checker.sv
`include "midi_overlapping_note_filter_macros.svh"

module mofilt_checker
    import mofilt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_status,
    input logic [7:0] out_data_one,
    input logic [7:0] out_data_two,
    input logic       last_of_run
);

    // An inserted note-off is a clean note-off with zero velocity.
    `MOFILT_ASSERT_NOW(a_kill_form, clk, rst_n, out_valid && !last_of_run, (out_status[7:4] == TYPE_NOTE_OFF) && (out_data_two == 8'd0) && !out_data_one[7], "inserted note-off malformed")

    // The item behind an inserted note-off is already queued.
    `MOFILT_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid && last_of_run, "second result of a pair missing")

    // A stalled result holds.
    `MOFILT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_data_one) && $stable(out_data_two) && $stable(last_of_run), "stalled result changed")

endmodule

bind midi_overlapping_note_filter mofilt_checker u_checker (.*);
